FILE: rtl/assert_macros.svh
// Assertion macros shared by the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with reset disable.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check with reset disable.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pdaf_pkg.sv
package pdaf_pkg;

	localparam int unsigned PIX_W          = 8;
	localparam int unsigned FIFO_DEPTH_DEF = 8;

	typedef logic [PIX_W-1:0] pix_t;

	// One result waiting for the output port.
	typedef struct packed {
		logic row_end;
		pix_t pixel;
	} result_t;

	// Up to three results produced by one column, in output order.
	typedef struct packed {
		logic [2:0]    vld;
		result_t [2:0] res;
	} push_t;

	function automatic pix_t absdiff(input pix_t a, input pix_t b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic pix_t ravg(input pix_t a, input pix_t b);
		logic [PIX_W:0] sum;
		sum  = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
		ravg = sum[PIX_W:1];
	endfunction

	// Gated five-tap smoother: f1/n1 on one side, n2/f2 on the other.
	function automatic pix_t gated_smooth(input pix_t c, input pix_t f1, input pix_t n1,
			input pix_t n2, input pix_t f2, input pix_t lim);
		logic pass;
		pix_t k3;
		pass = (absdiff(c, f1) < lim) && (absdiff(c, n1) < lim) &&
			(absdiff(c, n2) < lim) && (absdiff(c, f2) < lim);
		k3 = ravg(ravg(f1, n1), ravg(f2, n2));
		gated_smooth = pass ? ravg(k3, c) : c;
	endfunction

endpackage

FILE: rtl/pdaf_fifo.sv
module pdaf_fifo #(
	parameter int unsigned DEPTH = pdaf_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_en,
	input  pdaf_pkg::push_t   push,
	output logic              room,
	output logic              m_tvalid,
	input  logic              m_tready,
	output pdaf_pkg::result_t head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pdaf_pkg::result_t q_mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  off1, off2;
	logic [CNT_W-1:0]  npush;
	logic              pop;

	assign off1  = PTR_W'(push.vld[0]);
	assign off2  = PTR_W'(push.vld[0]) + PTR_W'(push.vld[1]);
	assign npush = push_en ? (CNT_W'(push.vld[0]) + CNT_W'(push.vld[1]) +
		CNT_W'(push.vld[2])) : '0;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != '0);
	assign head     = q_mem[rd_ptr_q];
	// three slots must be free before a column may drain into the queue
	assign room     = (count_q <= CNT_W'(DEPTH - 3));

	// compacted write: present results land in consecutive slots
	always_ff @(posedge clk) begin
		if (push_en) begin
			if (push.vld[0]) q_mem[wr_ptr_q]        <= push.res[0];
			if (push.vld[1]) q_mem[wr_ptr_q + off1] <= push.res[1];
			if (push.vld[2]) q_mem[wr_ptr_q + off2] <= push.res[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(npush);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + npush - CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/postproc_down_across_filter.sv
// Channel | Dir | tdata (low bit up)                                  | tlast
// s_*     | in  | above_far, above_near, center_pixel, below_near,    | last_in_row
//         |     | below_far, flimit (8 bits each, 48 bits)            |
// m_*     | out | pixel_out (8 bits)                                  | row_end
//
// One column is taken per cycle while s_tready is high. Stage 1 registers the
// input and runs the vertical smoother; stage 2 runs the horizontal window
// and drops 0..3 results into a FIFO_DEPTH-entry output queue that drives the
// master port. Each column passes the stage 1, stage 2 and queue registers;
// it comes out two columns later, or at the row's last column, which flushes.
// s_tready falls only when the queue has fewer than three free slots; it does
// not depend on m_tready combinationally. arst_n clears stage valids, the
// window, the limit history, the column count and the queue pointers.
// FIFO_DEPTH must be a power of two, at least 4.
module postproc_down_across_filter #(
	parameter int unsigned FIFO_DEPTH = pdaf_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // above_far, above_near, center_pixel, below_near,
	                               // below_far, flimit
	input  logic        s_tlast,   // last_in_row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // pixel_out
	output logic        m_tlast    // row_end
);

	typedef pdaf_pkg::pix_t pix_t;

	// stage 1: raw column
	logic        valid_s1;
	logic [47:0] data_s1;
	logic        last_s1;

	// stage 2: vertical result
	logic valid_s2;
	pix_t x_s2, lim_s2;
	logic last_s2;

	// horizontal state
	pix_t       vert_window_q [4];
	pix_t       limit_delay_q [2];
	logic [1:0] cols_q;

	logic            room;
	logic            take_s2, load_s2, load_s1;
	pix_t            x_v;
	pix_t            win [4];
	pix_t            seq [7];
	pdaf_pkg::push_t push;
	pdaf_pkg::result_t head;

	assign take_s2  = valid_s2 && room;
	assign load_s2  = !valid_s2 || take_s2;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	// vertical pass on the registered column
	assign x_v = pdaf_pkg::gated_smooth(data_s1[23:16], data_s1[7:0], data_s1[15:8],
		data_s1[31:24], data_s1[39:32], data_s1[47:40]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= s_tvalid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (load_s2 && valid_s1) begin
			x_s2    <= x_v;
			lim_s2  <= data_s1[47:40];
			last_s2 <= last_s1;
		end
	end

	// first column of a row fills the window (left-edge replication);
	// right edge replicates the newest column
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			win[i] = (cols_q == 2'd0) ? x_s2 : vert_window_q[i];
			seq[i] = win[i];
		end
		seq[4] = x_s2;
		seq[5] = x_s2;
		seq[6] = x_s2;
	end

	always_comb begin
		push.vld[0] = (cols_q == 2'd2);
		push.vld[1] = last_s2 && (cols_q != 2'd0);
		push.vld[2] = last_s2;
		push.res[0].pixel = pdaf_pkg::gated_smooth(seq[2], seq[0], seq[1], seq[3], seq[4],
			limit_delay_q[0]);
		push.res[0].row_end = 1'b0;
		push.res[1].pixel = pdaf_pkg::gated_smooth(seq[3], seq[1], seq[2], seq[4], seq[5],
			limit_delay_q[1]);
		push.res[1].row_end = 1'b0;
		push.res[2].pixel = pdaf_pkg::gated_smooth(seq[4], seq[2], seq[3], seq[5], seq[6],
			lim_s2);
		push.res[2].row_end = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) vert_window_q[i] <= '0;
			limit_delay_q[0] <= '0;
			limit_delay_q[1] <= '0;
			cols_q           <= 2'd0;
		end else if (take_s2) begin
			for (int i = 0; i < 3; i++) vert_window_q[i] <= win[i+1];
			vert_window_q[3] <= x_s2;
			limit_delay_q[0] <= limit_delay_q[1];
			limit_delay_q[1] <= lim_s2;
			priority if (last_s2) cols_q <= 2'd0;
			else if (cols_q == 2'd2) cols_q <= 2'd2;
			else cols_q <= cols_q + 2'd1;
		end
	end

	pdaf_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (take_s2),
		.push    (push),
		.room    (room),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.head    (head)
	);

	assign m_tdata = head.pixel;
	assign m_tlast = head.row_end;

endmodule

FILE: rtl/pdaf_checker.sv
`include "assert_macros.svh"

module pdaf_checker #(
	parameter int unsigned FIFO_DEPTH = pdaf_pkg::FIFO_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	logic        in_xfer, out_xfer;
	logic [15:0] pend_q;      // columns taken but not yet delivered
	logic [15:0] rows_q;      // row ends taken but not yet delivered

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			rows_q <= '0;
		end else begin
			pend_q <= pend_q + 16'(in_xfer) - 16'(out_xfer);
			rows_q <= rows_q + 16'(in_xfer && s_tlast) - 16'(out_xfer && m_tlast);
		end
	end

	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
	`CHK_IMPL(a_no_invented, clk, arst_n, out_xfer, pend_q != 16'd0, "output without a pending column")
	`CHK_IMPL(a_row_end_owed, clk, arst_n, out_xfer && m_tlast, rows_q != 16'd0, "row end without a taken last column")
	`CHK_IMPL(a_pend_bound, clk, arst_n, 1'b1, pend_q <= 16'(FIFO_DEPTH + 4), "too many columns held")

endmodule

bind postproc_down_across_filter pdaf_checker #(
	.FIFO_DEPTH(FIFO_DEPTH)
) u_pdaf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
